/* sv/tstw_pkg.sv */
package tstw_pkg;

    // default screen geometry
    localparam int ROWS_DEF = 30;
    localparam int COLS_DEF = 40;

    // result field widths
    localparam int OUT_ROW_W = 5;
    localparam int OUT_COL_W = 6;

    // character codes and masks
    localparam logic [7:0] CHAR_SPACE  = 8'h20;
    localparam logic [7:0] CHAR_TAB    = 8'h09;
    localparam logic [7:0] CHAR_LF     = 8'h0A;
    localparam logic [7:0] CHAR_CR     = 8'h0D;
    localparam logic [7:0] INV_MASK    = 8'h80;
    localparam logic [7:0] TAB_MASK    = 8'hF8;
    localparam logic [7:0] COLOR_RESET = 8'd15;

    typedef enum logic [1:0] {
        OP_PUT        = 2'd0,
        OP_SET_CURSOR = 2'd1,
        OP_SET_COLOR  = 2'd2,
        OP_READ       = 2'd3
    } t_op;

    typedef enum logic [3:0] {
        S_CLEAR,
        S_IDLE,
        S_TOG_RD,
        S_TOG_WR,
        S_ACT,
        S_RD_WAIT,
        S_SCR_COL_RD,
        S_SCR_COL_WR,
        S_SCR_FILL,
        S_TOG2_RD,
        S_TOG2_WR,
        S_DONE
    } t_state;

    typedef struct packed {
        logic [OUT_ROW_W-1:0] cursor_row;
        logic [OUT_COL_W-1:0] cursor_column;
        logic [7:0]           cell_char;
        logic [7:0]           cell_color;
    } t_result;

endpackage

/* sv/text_screen_terminal_writer.sv */
// Text-mode terminal writer with a cursor, one color per row and scroll.
// Request channel s_axis_*: tuser carries the operation (put character, set
// cursor, set row color, read cell), tdata the character, row, column and
// color. Every item yields exactly one result item on m_axis_*: the cursor
// after the operation, plus the cell byte and row color for a read (else 0).
// Config channel i_cfg_*: one bit, invert_cursor; write it only while idle.
// Characters live in a ROWS*COLS byte RAM, colors in a ROWS byte RAM, both
// with a registered read port. Rows are kept in a circular order behind a top
// pointer, so a scroll only refills one row instead of moving the screen.
// Steps per item: a read cell reads both RAMs, then captures the data; a put
// with inversion on flips the cell under the cursor before and after the move;
// a put that scrolls clears the new bottom row with one RAM write per cell.
// The sequencer handles one item at a time, so the next item is taken once
// the result has moved into the output register.
// Reset (i_rst_n low, synchronous) homes the cursor and starts a clearing
// pass over all ROWS*COLS cells (1200 by default) that fills spaces and color 15;
// s_axis_tready stays low until it ends. Config writes are always taken.
// If the receiver stalls, the result waits in the output register; one more
// item is worked on and then held until the register frees up.
module text_screen_terminal_writer #(
    parameter int ROWS = tstw_pkg::ROWS_DEF,
    parameter int COLS = tstw_pkg::COLS_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [31:0] s_axis_tdata,   // char_code, row, column, color
    input  logic [1:0]  s_axis_tuser,   // operation
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [31:0] m_axis_tdata,   // cursor_row, cursor_column, cell_char, cell_color
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic        i_cfg_data      // invert_cursor
);

    import tstw_pkg::*;

    localparam int CELLS = ROWS * COLS;
    localparam int CAW   = $clog2(CELLS);
    localparam int RW    = $clog2(ROWS);

    logic           r_invert;
    logic           r_ovalid;
    t_result        r_result;

    logic           out_free;
    logic           done;
    t_result        result;

    logic           cm_we, cm_re, km_we, km_re;
    logic [CAW-1:0] cm_waddr, cm_raddr;
    logic [RW-1:0]  km_waddr, km_raddr;
    logic [7:0]     cm_wdata, cm_rdata, km_wdata, km_rdata;

    // config register
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_invert <= 1'b0;
        end else if (i_cfg_valid) begin
            r_invert <= i_cfg_data;
        end
    end

    // output register
    assign out_free = !r_ovalid || m_axis_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ovalid <= 1'b0;
        end else if (done) begin
            r_ovalid <= 1'b1;
        end else if (m_axis_tready) begin
            r_ovalid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (done) begin
            r_result <= result;
        end
    end

    assign m_axis_tvalid = r_ovalid;
    assign m_axis_tdata  = {5'd0, r_result.cell_color, r_result.cell_char,
                            r_result.cursor_column, r_result.cursor_row};

    tstw_ctrl #(
        .ROWS (ROWS),
        .COLS (COLS)
    ) u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (s_axis_tvalid),
        .o_in_ready (s_axis_tready),
        .i_op       (t_op'(s_axis_tuser)),
        .i_char     (s_axis_tdata[7:0]),
        .i_row      (s_axis_tdata[15:8]),
        .i_col      (s_axis_tdata[23:16]),
        .i_color    (s_axis_tdata[31:24]),
        .i_invert   (r_invert),
        .i_out_free (out_free),
        .o_done     (done),
        .o_result   (result),
        .o_cm_we    (cm_we),
        .o_cm_waddr (cm_waddr),
        .o_cm_wdata (cm_wdata),
        .o_cm_re    (cm_re),
        .o_cm_raddr (cm_raddr),
        .i_cm_rdata (cm_rdata),
        .o_km_we    (km_we),
        .o_km_waddr (km_waddr),
        .o_km_wdata (km_wdata),
        .o_km_re    (km_re),
        .o_km_raddr (km_raddr),
        .i_km_rdata (km_rdata)
    );

    // character store, rows in circular order
    tstw_ram #(
        .DEPTH (CELLS)
    ) u_char_ram (
        .i_clk   (i_clk),
        .i_we    (cm_we),
        .i_waddr (cm_waddr),
        .i_wdata (cm_wdata),
        .i_re    (cm_re),
        .i_raddr (cm_raddr),
        .o_rdata (cm_rdata)
    );

    // row colors, same circular order
    tstw_ram #(
        .DEPTH (ROWS)
    ) u_color_ram (
        .i_clk   (i_clk),
        .i_we    (km_we),
        .i_waddr (km_waddr),
        .i_wdata (km_wdata),
        .i_re    (km_re),
        .i_raddr (km_raddr),
        .o_rdata (km_rdata)
    );

endmodule

/* sv/tstw_ram.sv */
module tstw_ram #(
    parameter int DEPTH = 2,
    localparam int AW = $clog2(DEPTH)
) (
    input  logic          i_clk,
    input  logic          i_we,
    input  logic [AW-1:0] i_waddr,
    input  logic [7:0]    i_wdata,
    input  logic          i_re,
    input  logic [AW-1:0] i_raddr,
    output logic [7:0]    o_rdata
);

    logic [7:0] mem [DEPTH];
    logic [7:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

/* sv/tstw_ctrl.sv */
module tstw_ctrl #(
    parameter int ROWS = tstw_pkg::ROWS_DEF,
    parameter int COLS = tstw_pkg::COLS_DEF,
    localparam int CELLS = ROWS * COLS,
    localparam int CAW = $clog2(CELLS),
    localparam int RW = $clog2(ROWS),
    localparam int CW = $clog2(COLS)
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    // request side
    input  logic              i_in_valid,
    output logic              o_in_ready,
    input  tstw_pkg::t_op     i_op,
    input  logic [7:0]        i_char,
    input  logic [7:0]        i_row,
    input  logic [7:0]        i_col,
    input  logic [7:0]        i_color,
    input  logic              i_invert,
    // result side
    input  logic              i_out_free,
    output logic              o_done,
    output tstw_pkg::t_result o_result,
    // character store port
    output logic              o_cm_we,
    output logic [CAW-1:0]    o_cm_waddr,
    output logic [7:0]        o_cm_wdata,
    output logic              o_cm_re,
    output logic [CAW-1:0]    o_cm_raddr,
    input  logic [7:0]        i_cm_rdata,
    // row color store port
    output logic              o_km_we,
    output logic [RW-1:0]     o_km_waddr,
    output logic [7:0]        o_km_wdata,
    output logic              o_km_re,
    output logic [RW-1:0]     o_km_raddr,
    input  logic [7:0]        i_km_rdata
);

    import tstw_pkg::*;

    t_state         r_state, n_state;
    t_op            r_op, n_op;
    logic [7:0]     r_char, n_char;
    logic [RW-1:0]  r_row_in, n_row_in;
    logic [CW-1:0]  r_col_in, n_col_in;
    logic [7:0]     r_color, n_color;
    logic           r_inv, n_inv;
    logic [RW-1:0]  r_row, n_row;
    logic [CW-1:0]  r_col, n_col;
    logic [RW-1:0]  r_top, n_top;
    logic [RW-1:0]  r_fill_row, n_fill_row;
    logic [CAW-1:0] r_cnt, n_cnt;
    logic [7:0]     r_rd_char, n_rd_char;
    logic [7:0]     r_rd_color, n_rd_color;

    logic [CAW-1:0] cur_addr;
    logic [7:0]     row8, col8, row_cl, col_cl;

    // logical row -> physical row of the circular store
    function automatic logic [RW-1:0] f_phys(input logic [RW-1:0] top,
                                             input logic [RW-1:0] lr);
        logic [RW:0] s;
        s = {1'b0, top} + {1'b0, lr};
        if (s >= (RW+1)'(ROWS)) begin
            s = s - (RW+1)'(ROWS);
        end
        return s[RW-1:0];
    endfunction

    function automatic logic [CAW-1:0] f_addr(input logic [RW-1:0] prow,
                                              input logic [CW-1:0] col);
        return CAW'(prow) * CAW'(COLS) + CAW'(col);
    endfunction

    assign cur_addr = f_addr(f_phys(r_top, r_row), r_col);
    assign row_cl   = (i_row >= 8'(ROWS)) ? 8'(ROWS - 1) : i_row;
    assign col_cl   = (i_col >= 8'(COLS)) ? 8'(COLS - 1) : i_col;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLEAR;
            r_row   <= '0;
            r_col   <= '0;
            r_top   <= '0;
            r_cnt   <= '0;
        end else begin
            r_state <= n_state;
            r_row   <= n_row;
            r_col   <= n_col;
            r_top   <= n_top;
            r_cnt   <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        r_op       <= n_op;
        r_char     <= n_char;
        r_row_in   <= n_row_in;
        r_col_in   <= n_col_in;
        r_color    <= n_color;
        r_inv      <= n_inv;
        r_fill_row <= n_fill_row;
        r_rd_char  <= n_rd_char;
        r_rd_color <= n_rd_color;
    end

    always_comb begin
        logic [7:0] tab_col;
        logic       adv;
        logic       last_row;

        n_state    = r_state;
        n_op       = r_op;
        n_char     = r_char;
        n_row_in   = r_row_in;
        n_col_in   = r_col_in;
        n_color    = r_color;
        n_inv      = r_inv;
        n_row      = r_row;
        n_col      = r_col;
        n_top      = r_top;
        n_fill_row = r_fill_row;
        n_cnt      = r_cnt;
        n_rd_char  = r_rd_char;
        n_rd_color = r_rd_color;

        o_in_ready = 1'b0;
        o_done     = 1'b0;
        o_cm_we    = 1'b0;
        o_cm_waddr = cur_addr;
        o_cm_wdata = CHAR_SPACE;
        o_cm_re    = 1'b0;
        o_cm_raddr = cur_addr;
        o_km_we    = 1'b0;
        o_km_waddr = r_top;
        o_km_wdata = COLOR_RESET;
        o_km_re    = 1'b0;
        o_km_raddr = r_top;

        tab_col  = (8'(r_col) + 8'd8) & TAB_MASK;
        adv      = 1'b0;
        last_row = (r_row == RW'(ROWS - 1));

        case (r_state)
            S_CLEAR: begin
                o_cm_we    = 1'b1;
                o_cm_waddr = r_cnt;
                o_cm_wdata = CHAR_SPACE;
                if (r_cnt < CAW'(ROWS)) begin
                    o_km_we    = 1'b1;
                    o_km_waddr = r_cnt[RW-1:0];
                    o_km_wdata = COLOR_RESET;
                end
                if (r_cnt == CAW'(CELLS - 1)) begin
                    n_cnt   = '0;
                    n_state = S_IDLE;
                end else begin
                    n_cnt = r_cnt + CAW'(1);
                end
            end
            S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    n_op       = i_op;
                    n_char     = i_char;
                    n_row_in   = RW'(row_cl);
                    n_col_in   = CW'(col_cl);
                    n_color    = i_color;
                    n_inv      = i_invert;
                    n_rd_char  = '0;
                    n_rd_color = '0;
                    n_state    = (i_op == OP_PUT && i_invert) ? S_TOG_RD : S_ACT;
                end
            end
            S_TOG_RD: begin
                o_cm_re = 1'b1;
                n_state = S_TOG_WR;
            end
            S_TOG_WR: begin
                o_cm_we    = 1'b1;
                o_cm_wdata = i_cm_rdata ^ INV_MASK;
                n_state    = S_ACT;
            end
            S_ACT: begin
                case (r_op)
                    OP_PUT: begin
                        case (r_char)
                            CHAR_TAB: begin
                                if (tab_col >= 8'(COLS)) begin
                                    n_col = '0;
                                    adv   = 1'b1;
                                end else begin
                                    n_col = CW'(tab_col);
                                end
                            end
                            CHAR_LF: begin
                                adv = 1'b1;
                            end
                            CHAR_CR: begin
                                n_col = '0;
                            end
                            default: begin
                                o_cm_we    = 1'b1;
                                o_cm_wdata = r_char;
                                if (r_col == CW'(COLS - 1)) begin
                                    n_col = '0;
                                    adv   = 1'b1;
                                end else begin
                                    n_col = r_col + CW'(1);
                                end
                            end
                        endcase
                        if (adv && !last_row) begin
                            n_row = r_row + RW'(1);
                        end
                        if (adv && last_row) begin
                            n_state = S_SCR_COL_RD;
                        end else begin
                            n_state = r_inv ? S_TOG2_RD : S_DONE;
                        end
                    end
                    OP_SET_CURSOR: begin
                        n_row   = r_row_in;
                        n_col   = r_col_in;
                        n_state = S_DONE;
                    end
                    OP_SET_COLOR: begin
                        o_km_we    = 1'b1;
                        o_km_waddr = f_phys(r_top, r_row);
                        o_km_wdata = r_color;
                        n_state    = S_DONE;
                    end
                    default: begin
                        o_cm_re    = 1'b1;
                        o_cm_raddr = f_addr(f_phys(r_top, r_row_in), r_col_in);
                        o_km_re    = 1'b1;
                        o_km_raddr = f_phys(r_top, r_row_in);
                        n_state    = S_RD_WAIT;
                    end
                endcase
            end
            S_RD_WAIT: begin
                n_rd_char  = i_cm_rdata;
                n_rd_color = i_km_rdata;
                n_state    = S_DONE;
            end
            S_SCR_COL_RD: begin
                // color of the current bottom row
                o_km_re    = 1'b1;
                o_km_raddr = f_phys(r_top, RW'(ROWS - 1));
                n_state    = S_SCR_COL_WR;
            end
            S_SCR_COL_WR: begin
                // old top row becomes the new bottom row
                o_km_we    = 1'b1;
                o_km_waddr = r_top;
                o_km_wdata = i_km_rdata;
                n_fill_row = r_top;
                n_top      = (r_top == RW'(ROWS - 1)) ? '0 : r_top + RW'(1);
                n_cnt      = '0;
                n_state    = S_SCR_FILL;
            end
            S_SCR_FILL: begin
                o_cm_we    = 1'b1;
                o_cm_waddr = f_addr(r_fill_row, r_cnt[CW-1:0]);
                o_cm_wdata = CHAR_SPACE;
                if (r_cnt == CAW'(COLS - 1)) begin
                    n_cnt   = '0;
                    n_state = r_inv ? S_TOG2_RD : S_DONE;
                end else begin
                    n_cnt = r_cnt + CAW'(1);
                end
            end
            S_TOG2_RD: begin
                o_cm_re = 1'b1;
                n_state = S_TOG2_WR;
            end
            S_TOG2_WR: begin
                o_cm_we    = 1'b1;
                o_cm_wdata = i_cm_rdata ^ INV_MASK;
                n_state    = S_DONE;
            end
            S_DONE: begin
                if (i_out_free) begin
                    o_done  = 1'b1;
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    assign row8 = 8'(r_row);
    assign col8 = 8'(r_col);

    assign o_result.cursor_row    = row8[OUT_ROW_W-1:0];
    assign o_result.cursor_column = col8[OUT_COL_W-1:0];
    assign o_result.cell_char     = r_rd_char;
    assign o_result.cell_color    = r_rd_color;

`ifndef SYNTH
    a_row_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state != S_CLEAR |-> r_row < RW'(ROWS))
        else $error("cursor row out of range");

    a_col_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state != S_CLEAR |-> CAW'(r_col) < CAW'(COLS))
        else $error("cursor column out of range");

    a_top_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state != S_CLEAR |-> r_top < RW'(ROWS))
        else $error("top row pointer out of range");

    a_no_rw_clash: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(o_cm_we && o_cm_re && o_cm_waddr == o_cm_raddr))
        else $error("read and write of one cell in one cycle");

    a_scroll_fill: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == S_SCR_COL_WR |=> r_state == S_SCR_FILL && r_cnt == '0)
        else $error("scroll did not start the row fill");
`endif

endmodule

/* tb/terminal_screen_checker.sv */
`timescale 1ns / 1ps

// Watches the request, result and config channels of the terminal writer,
// keeps its own copy of the screen and predicts every result item.
module terminal_screen_checker #(
    parameter int ROWS = tstw_pkg::ROWS_DEF,
    parameter int COLS = tstw_pkg::COLS_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_tvalid,
    input  logic        s_tready,
    input  logic [31:0] s_tdata,
    input  logic [1:0]  s_tuser,
    input  logic        m_tvalid,
    input  logic        m_tready,
    input  logic [31:0] m_tdata,
    input  logic        cfg_valid,
    input  logic        cfg_ready,
    input  logic        cfg_data,
    output int          o_errors,
    output int          o_pending
);

    import tstw_pkg::*;

    typedef struct packed {
        logic [OUT_ROW_W-1:0] row;
        logic [OUT_COL_W-1:0] col;
        logic [7:0]           ch;
        logic [7:0]           color;
    } t_cursor_reply;

    logic [7:0]    screen [ROWS*COLS];
    logic [7:0]    row_color [ROWS];
    int            cur_r;
    int            cur_c;
    bit            invert_on;
    t_cursor_reply reply_q [$];

    initial begin
        o_errors  = 0;
        o_pending = 0;
    end

    function automatic void clear_screen();
        foreach (screen[i]) screen[i] = CHAR_SPACE;
        foreach (row_color[i]) row_color[i] = COLOR_RESET;
        cur_r     = 0;
        cur_c     = 0;
        invert_on = 1'b0;
        reply_q.delete();
    endfunction

    function automatic void flip_under_cursor();
        if (invert_on)
            screen[cur_r*COLS + cur_c] ^= INV_MASK;
    endfunction

    // whole screen moves up; the new bottom row copies the color above it
    function automatic void scroll_screen();
        for (int i = 0; i < (ROWS-1)*COLS; i++)
            screen[i] = screen[i+COLS];
        for (int i = (ROWS-1)*COLS; i < ROWS*COLS; i++)
            screen[i] = CHAR_SPACE;
        for (int r = 0; r < ROWS-1; r++)
            row_color[r] = row_color[r+1];
        row_color[ROWS-1] = row_color[ROWS-2];
    endfunction

    function automatic void next_row();
        if (cur_r >= ROWS-1)
            scroll_screen();
        else
            cur_r++;
    endfunction

    function automatic void put_char(logic [7:0] c);
        flip_under_cursor();
        if (c == CHAR_TAB) begin
            cur_c = (cur_c + 8) & int'(TAB_MASK);
            if (cur_c >= COLS) begin
                cur_c = 0;
                next_row();
            end
        end else if (c == CHAR_LF) begin
            next_row();
        end else if (c == CHAR_CR) begin
            cur_c = 0;
        end else begin
            screen[cur_r*COLS + cur_c] = c;
            cur_c++;
            if (cur_c >= COLS) begin
                cur_c = 0;
                next_row();
            end
        end
        flip_under_cursor();
    endfunction

    function automatic t_cursor_reply apply_terminal_op(t_op op, logic [31:0] data);
        t_cursor_reply rep;
        int            r;
        int            c;
        r   = int'(data[15:8]);
        c   = int'(data[23:16]);
        rep = '0;
        if (r >= ROWS) r = ROWS-1;
        if (c >= COLS) c = COLS-1;
        case (op)
            OP_PUT: begin
                put_char(data[7:0]);
            end
            OP_SET_CURSOR: begin
                cur_r = r;
                cur_c = c;
            end
            OP_SET_COLOR: begin
                row_color[cur_r] = data[31:24];
            end
            default: begin
                rep.ch    = screen[r*COLS + c];
                rep.color = row_color[r];
            end
        endcase
        rep.row = OUT_ROW_W'(cur_r);
        rep.col = OUT_COL_W'(cur_c);
        return rep;
    endfunction

    function automatic void check_field(string name, int want, int got);
        if (want != got) begin
            $display("%0t ns: %s mismatch, expected %0d actual %0d", $time, name, want, got);
            o_errors++;
        end
    endfunction

    always @(posedge i_clk) begin
        t_cursor_reply want;
        t_cursor_reply got;
        if (!i_rst_n) begin
            clear_screen();
        end else begin
            if (cfg_valid && cfg_ready)
                invert_on = cfg_data;
            if (m_tvalid && m_tready) begin
                // result fields from the lowest bit up
                got.row   = m_tdata[OUT_ROW_W-1:0];
                got.col   = m_tdata[OUT_ROW_W +: OUT_COL_W];
                got.ch    = m_tdata[OUT_ROW_W+OUT_COL_W +: 8];
                got.color = m_tdata[OUT_ROW_W+OUT_COL_W+8 +: 8];
                if (reply_q.size() == 0) begin
                    $display("%0t ns: result item with nothing expected, actual %h",
                             $time, m_tdata);
                    o_errors++;
                end else begin
                    want = reply_q.pop_front();
                    check_field("cursor_row", int'(want.row), int'(got.row));
                    check_field("cursor_column", int'(want.col), int'(got.col));
                    check_field("cell_char", int'(want.ch), int'(got.ch));
                    check_field("cell_color", int'(want.color), int'(got.color));
                end
            end
            if (s_tvalid && s_tready)
                reply_q.push_back(apply_terminal_op(t_op'(s_tuser), s_tdata));
        end
        o_pending = reply_q.size();
    end

endmodule

/* tb/tb_text_screen_terminal_writer.sv */
`timescale 1ns / 1ps

// Drives the terminal writer with directed and random operations, with
// bursty request traffic and a wandering stall pattern on the result side.
// The checker next to the block predicts and compares every result item.
module tb_text_screen_terminal_writer;
    import tstw_pkg::*;

    localparam int ROWS = ROWS_DEF;
    localparam int COLS = COLS_DEF;

    // receiver stall patterns
    localparam int RX_OPEN   = 0;
    localparam int RX_COIN   = 1;
    localparam int RX_STARVE = 2;
    localparam int RX_BEAT   = 3;

    logic        i_clk     = 1'b0;
    logic        i_rst_n   = 1'b0;
    logic        s_tvalid  = 1'b0;
    logic        s_tready;
    logic [31:0] s_tdata   = '0;   // char_code, row, column, color
    logic [1:0]  s_tuser   = OP_PUT;   // operation
    logic        m_tvalid;
    logic        m_tready  = 1'b0;
    logic [31:0] m_tdata;          // cursor_row, cursor_column, cell_char, cell_color
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic        cfg_data  = 1'b0;

    int errors;
    int pending;
    int burst_left = 0;
    int rx_mode    = RX_OPEN;
    int rx_left    = 0;
    int rx_tick    = 0;

    text_screen_terminal_writer #(
        .ROWS(ROWS),
        .COLS(COLS)
    ) dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_tvalid),
        .s_axis_tready (s_tready),
        .s_axis_tdata  (s_tdata),
        .s_axis_tuser  (s_tuser),
        .m_axis_tvalid (m_tvalid),
        .m_axis_tready (m_tready),
        .m_axis_tdata  (m_tdata),
        .i_cfg_valid   (cfg_valid),
        .o_cfg_ready   (cfg_ready),
        .i_cfg_data    (cfg_data)
    );

    terminal_screen_checker #(
        .ROWS(ROWS),
        .COLS(COLS)
    ) u_checker (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data),
        .o_errors  (errors),
        .o_pending (pending)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // hard stop well past the slowest legal run
    initial begin
        #10_000_000;
        $display("tb_text_screen_terminal_writer: done, errors");
        $finish;
    end

    // result side: switch between stall patterns every so often
    always @(negedge i_clk) begin
        if (rx_left == 0) begin
            rx_mode = int'($urandom_range(RX_OPEN, RX_BEAT));
            rx_left = int'($urandom_range(20, 200));
        end
        rx_left--;
        rx_tick++;
        case (rx_mode)
            RX_OPEN:   m_tready <= 1'b1;
            RX_COIN:   m_tready <= 1'($urandom_range(0, 1));
            RX_STARVE: m_tready <= ($urandom_range(0, 7) == 0);
            default:   m_tready <= (rx_tick % 5 != 0);
        endcase
    end

    function automatic logic [31:0] pack_request(logic [7:0] ch, logic [7:0] row,
                                                 logic [7:0] col, logic [7:0] color);
        return {color, col, row, ch};
    endfunction

    // one request item; bursts of back-to-back items separated by random gaps
    task automatic send_request(t_op op, logic [31:0] data);
        int gap;
        if (burst_left == 0) begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : int'($urandom_range(1, 8));
            repeat (gap) begin
                @(negedge i_clk);
                s_tvalid <= 1'b0;
            end
            burst_left = ($urandom_range(0, 4) == 0) ? int'($urandom_range(30, 80))
                                                     : int'($urandom_range(1, 10));
        end
        burst_left--;
        @(negedge i_clk);
        s_tvalid <= 1'b1;
        s_tdata  <= data;
        s_tuser  <= op;
        do @(posedge i_clk); while (!s_tready);
    endtask

    // stop sending and let every result drain, bounded
    task automatic wait_idle();
        int guard;
        guard = 0;
        @(negedge i_clk);
        s_tvalid <= 1'b0;
        while (pending != 0 && guard < 200_000) begin
            @(negedge i_clk);
            guard++;
        end
        repeat (COLS + 16) @(negedge i_clk);
    endtask

    task automatic write_invert(logic v);
        @(negedge i_clk);
        cfg_valid <= 1'b1;
        cfg_data  <= v;
        do @(posedge i_clk); while (!cfg_ready);
        @(negedge i_clk);
        cfg_valid <= 1'b0;
    endtask

    // coordinate: mostly on screen, some far out, some at the edge
    function automatic logic [7:0] pick_coord(int limit);
        case ($urandom_range(0, 3))
            0:       return 8'($urandom_range(0, 255));
            1:       return 8'($urandom_range(limit - 4, limit - 1));
            default: return 8'($urandom_range(0, limit - 1));
        endcase
    endfunction

    // puts dominate so the cursor walks down and scrolls often
    task automatic run_random_phase(int n);
        int         w;
        logic [7:0] ch;
        t_op        op;
        for (int i = 0; i < n; i++) begin
            w = int'($urandom_range(0, 99));
            case ($urandom_range(0, 9))
                0:       ch = CHAR_TAB;
                1:       ch = CHAR_LF;
                2:       ch = CHAR_CR;
                3, 4:    ch = 8'($urandom_range(0, 255));
                default: ch = 8'($urandom_range(8'h21, 8'h7E));
            endcase
            if (w < 58)
                op = OP_PUT;
            else if (w < 70)
                op = OP_SET_CURSOR;
            else if (w < 78)
                op = OP_SET_COLOR;
            else
                op = OP_READ;
            // unused fields carry random noise
            send_request(op, pack_request(ch, pick_coord(ROWS), pick_coord(COLS),
                                          8'($urandom_range(0, 255))));
        end
    endtask

    initial begin
        repeat (4) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        write_invert(1'b0);

        // directed: reset contents, clamping, wrap with scroll, tab/LF/CR
        send_request(OP_READ,       pack_request(8'h00, 8'd0,   8'd0,   8'h00));
        send_request(OP_READ,       pack_request(8'h00, 8'd255, 8'd255, 8'h00));
        send_request(OP_SET_CURSOR, pack_request(8'h00, 8'd255, 8'd255, 8'h00));
        send_request(OP_SET_COLOR,  pack_request(8'h00, 8'd0,   8'd0,   8'h00));
        send_request(OP_PUT,        pack_request(8'h41, 8'd0,   8'd0,   8'h00));
        send_request(OP_READ,       pack_request(8'h00, 8'd28,  8'd39,  8'h00));
        send_request(OP_READ,       pack_request(8'h00, 8'd29,  8'd0,   8'h00));
        send_request(OP_SET_COLOR,  pack_request(8'hFF, 8'hFF,  8'hFF,  8'hFF));
        send_request(OP_SET_CURSOR, pack_request(8'h00, 8'd3,   8'd36,  8'h00));
        send_request(OP_PUT,        pack_request(CHAR_TAB, 8'd0, 8'd0,  8'h00));
        send_request(OP_SET_CURSOR, pack_request(8'h00, 8'd3,   8'd3,   8'h00));
        send_request(OP_PUT,        pack_request(CHAR_TAB, 8'd0, 8'd0,  8'h00));
        send_request(OP_PUT,        pack_request(8'h00, 8'd0,   8'd0,   8'h00));
        send_request(OP_PUT,        pack_request(8'hFF, 8'd0,   8'd0,   8'h00));
        send_request(OP_PUT,        pack_request(CHAR_LF, 8'd0, 8'd0,   8'h00));
        send_request(OP_PUT,        pack_request(CHAR_CR, 8'd0, 8'd0,   8'h00));
        send_request(OP_SET_CURSOR, pack_request(8'h00, 8'd29,  8'd5,   8'h00));
        send_request(OP_PUT,        pack_request(CHAR_LF, 8'd0, 8'd0,   8'h00));
        send_request(OP_READ,       pack_request(8'h00, 8'd3,   8'd10,  8'h00));
        wait_idle();

        // inverted cursor: toggled bit shows up on reads
        write_invert(1'b1);
        send_request(OP_SET_CURSOR, pack_request(8'h00, 8'd10,  8'd10,  8'h00));
        send_request(OP_PUT,        pack_request(8'h5A, 8'd0,   8'd0,   8'h00));
        send_request(OP_READ,       pack_request(8'h00, 8'd10,  8'd10,  8'h00));
        send_request(OP_READ,       pack_request(8'h00, 8'd10,  8'd11,  8'h00));
        send_request(OP_PUT,        pack_request(CHAR_TAB, 8'd0, 8'd0,  8'h00));
        send_request(OP_PUT,        pack_request(CHAR_CR, 8'd0, 8'd0,   8'h00));
        wait_idle();

        // random phases; switching the bit leaves toggled cells behind
        write_invert(1'b0);
        run_random_phase(460);
        wait_idle();
        write_invert(1'b1);
        run_random_phase(460);
        wait_idle();
        write_invert(1'b0);
        run_random_phase(460);
        wait_idle();
        write_invert(1'b1);
        run_random_phase(470);
        wait_idle();

        if (errors == 0 && pending == 0) begin
            $display("tb_text_screen_terminal_writer: done, clean");
        end else begin
            $display("tb_text_screen_terminal_writer: done, errors");
        end
        $finish;
    end

endmodule

/* sim.f */
sv/tstw_pkg.sv
sv/tstw_ram.sv
sv/tstw_ctrl.sv
sv/text_screen_terminal_writer.sv
tb/terminal_screen_checker.sv
tb/tb_text_screen_terminal_writer.sv
